### design/b64cd_pkg.sv
// b64cd_pkg: types and constants shared by the base64 checked decoder
// no dependencies; used by b64cd_sextet and base64_checked_decoder
`default_nettype none

package b64cd_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADCHAR = 2'd1,
    ST_BADLEN  = 2'd2,
    ST_BADPAD  = 2'd3
  } status_t;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_PAD     = 8'h3D;

  localparam logic [5:0] SX_LOWER_BASE = 6'd26;
  localparam logic [5:0] SX_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SX_PLUS       = 6'd62;
  localparam logic [5:0] SX_SLASH      = 6'd63;

  localparam logic [1:0] PAD_MAX = 2'd3;

  typedef struct packed {
    logic [5:0] value;
    logic       is_pad;
    logic       bad;
  } sextet_t;

endpackage

`default_nettype wire

### design/base64_checked_decoder.sv
// base64_checked_decoder: streaming base64 decoder, standard and url-safe alphabets
// depends on b64cd_pkg and b64cd_sextet
// data path: an input beat passes through the input register, then the result register, to the result beat
// throughput: one character per cycle while out_stall is low, limited by the single decode stage
// reset: synchronous rst clears both stages, quad position, padding count and error
`default_nettype none

module base64_checked_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] char_in,
  input  wire logic       is_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      data_byte,
  output logic            byte_valid,
  output logic            end_of_string,
  output logic [1:0]      status
);

  logic                s1_valid;
  logic [7:0]          s1_char;
  logic                s1_last;
  logic                out_adv;
  logic                s1_fire;

  logic [1:0]          quad;
  logic [5:0]          leftover;
  logic [1:0]          pad_count;
  b64cd_pkg::status_t  error_code;

  logic [1:0]          quad_next;
  logic [5:0]          leftover_next;
  logic [1:0]          pad_count_next;
  b64cd_pkg::status_t  error_code_next;
  b64cd_pkg::status_t  flag;
  b64cd_pkg::status_t  status_next;
  logic [7:0]          byte_next;
  logic                byte_valid_next;
  b64cd_pkg::sextet_t  sx;

  assign out_adv  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_adv;
  assign s1_fire  = s1_valid && out_adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_char <= char_in;
      s1_last <= is_last;
    end
  end

  b64cd_sextet u_sextet (
    .ch (s1_char),
    .sx (sx)
  );

  always_comb begin
    flag           = b64cd_pkg::ST_OK;
    pad_count_next = pad_count;
    if (sx.is_pad) begin
      if (pad_count != b64cd_pkg::PAD_MAX) begin
        pad_count_next = pad_count + 2'd1;
      end
      if (pad_count_next == b64cd_pkg::PAD_MAX) begin
        flag = b64cd_pkg::ST_BADPAD;
      end
    end else if (sx.bad) begin
      flag = b64cd_pkg::ST_BADCHAR;
    end else if (pad_count != 2'd0) begin
      flag = b64cd_pkg::ST_BADPAD;
    end
    error_code_next = (error_code != b64cd_pkg::ST_OK) ? error_code : flag;

    byte_next       = 8'd0;
    byte_valid_next = !sx.is_pad;
    leftover_next   = 6'd0;
    case (quad)
      2'd0: begin
        leftover_next   = sx.value;
        byte_valid_next = 1'b0;
      end
      2'd1: begin
        byte_next     = {leftover, sx.value[5:4]};
        leftover_next = {2'd0, sx.value[3:0]};
      end
      2'd2: begin
        byte_next     = {leftover[3:0], sx.value[5:2]};
        leftover_next = {4'd0, sx.value[1:0]};
      end
      default: begin
        byte_next     = {leftover[1:0], sx.value};
        leftover_next = 6'd0;
      end
    endcase
    if (!byte_valid_next) begin
      byte_next = 8'd0;
    end
    quad_next = quad + 2'd1;

    status_next = b64cd_pkg::ST_OK;
    if (s1_last) begin
      status_next     = (quad_next != 2'd0) ? b64cd_pkg::ST_BADLEN : error_code_next;
      quad_next       = 2'd0;
      leftover_next   = 6'd0;
      pad_count_next  = 2'd0;
      error_code_next = b64cd_pkg::ST_OK;
    end
  end

  // string state
  always_ff @(posedge clk) begin
    if (rst) begin
      quad       <= 2'd0;
      leftover   <= 6'd0;
      pad_count  <= 2'd0;
      error_code <= b64cd_pkg::ST_OK;
    end else if (s1_fire) begin
      quad       <= quad_next;
      leftover   <= leftover_next;
      pad_count  <= pad_count_next;
      error_code <= error_code_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      data_byte     <= byte_next;
      byte_valid    <= byte_valid_next;
      end_of_string <= s1_last;
      status        <= status_next;
    end
  end

  a_status_final_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && !end_of_string |-> status == b64cd_pkg::ST_OK)
    else $error("status set on a beat that is not the end of string");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> data_byte == 8'd0)
    else $error("data byte nonzero without byte valid");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> quad == 2'd0 && pad_count == 2'd0 &&
      error_code == b64cd_pkg::ST_OK)
    else $error("string state not cleared after final character");

  a_quad_steps: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !s1_last |=> quad == $past(quad) + 2'd1)
    else $error("quad position did not advance");

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && s1_valid |-> in_stall)
    else $error("input taken while both stages are full");

endmodule

`default_nettype wire

### design/b64cd_sextet.sv
// b64cd_sextet: maps one character to its sextet value, pad and bad flags
// depends on b64cd_pkg
`default_nettype none

module b64cd_sextet (
  input  wire logic [7:0]        ch,
  output b64cd_pkg::sextet_t     sx
);

  always_comb begin
    sx.value  = 6'd0;
    sx.is_pad = 1'b0;
    sx.bad    = 1'b0;
    if (ch inside {[b64cd_pkg::CH_UPPER_A:b64cd_pkg::CH_UPPER_Z]}) begin
      sx.value = 6'(ch - b64cd_pkg::CH_UPPER_A);
    end else if (ch inside {[b64cd_pkg::CH_LOWER_A:b64cd_pkg::CH_LOWER_Z]}) begin
      sx.value = 6'(ch - b64cd_pkg::CH_LOWER_A) + b64cd_pkg::SX_LOWER_BASE;
    end else if (ch inside {[b64cd_pkg::CH_DIGIT_0:b64cd_pkg::CH_DIGIT_9]}) begin
      sx.value = 6'(ch - b64cd_pkg::CH_DIGIT_0) + b64cd_pkg::SX_DIGIT_BASE;
    end else if (ch inside {b64cd_pkg::CH_PLUS, b64cd_pkg::CH_MINUS}) begin
      sx.value = b64cd_pkg::SX_PLUS;
    end else if (ch inside {b64cd_pkg::CH_SLASH, b64cd_pkg::CH_UNDER}) begin
      sx.value = b64cd_pkg::SX_SLASH;
    end else if (ch == b64cd_pkg::CH_PAD) begin
      sx.is_pad = 1'b1;
    end else begin
      sx.bad = 1'b1;
    end
  end

endmodule

`default_nettype wire
